// ----- rtl/lmrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lmrt_pkg
// Shared constants and controller/datapath interface types for the look-back
// maximum ratio tracker.
// ----------------------------------------------------------------------------
package lmrt_pkg;

    localparam int PRICE_W   = 32;
    localparam int RATIO_W   = 32;
    localparam int LB_W      = 4;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LB_W-1:0]    LB_RESET  = 4'd5;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 32'h0100_0000;
    localparam logic [RATIO_W-1:0] RATIO_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic skip_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/lmrt_ram.sv -----
// ----------------------------------------------------------------------------
// lmrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ----- rtl/lmrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmrt_ctrl
// Sequencing state machine: accepts a sample, scans the window unless it starts
// a new path, commits the new price, runs the divider unless it is skipped and
// hands the result to the output register.
module lmrt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  lmrt_pkg::dp_status_t  status,
    output lmrt_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_SCAN     = 7'b000_0010,
        ST_DRAIN    = 7'b000_0100,
        ST_COMMIT   = 7'b000_1000,
        ST_DIV_INIT = 7'b001_0000,
        ST_DIV      = 7'b010_0000,
        ST_DONE     = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = s_tuser ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = status.skip_div ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lmrt_datapath.sv -----
// ----------------------------------------------------------------------------
// lmrt_datapath
// Price history RAM with fill tracking, window maximum scan, restoring
// divider for the Q8.24 ratio, configuration register and output register.
// ----------------------------------------------------------------------------
module lmrt_datapath #(
    parameter int MAX_LOOKBACK = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lmrt_pkg::ctrl_cmd_t                 cmd,
    output lmrt_pkg::dp_status_t                status,
    input  logic [lmrt_pkg::PRICE_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lmrt_pkg::LB_W-1:0]           cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata,
    output logic                                m_tuser
);

    localparam int CW        = $clog2(MAX_LOOKBACK + 1);
    localparam int RAM_DEPTH = 1 << CW;
    localparam int PW        = lmrt_pkg::PRICE_W;
    localparam int SW        = lmrt_pkg::STEP_W;

    logic [lmrt_pkg::LB_W-1:0] lookback_reg;
    logic [PW-1:0]             price_reg;
    logic                      newp_reg;
    logic [CW-1:0]             a_reg;
    logic [CW-1:0]             idx_reg;
    logic [CW-1:0]             head_reg;
    logic [CW-1:0]             fill_reg;
    logic                      pend_reg;
    logic                      pend_ok_reg;
    logic [PW-1:0]             acc_reg;
    logic [PW-1:0]             wmax_reg;
    logic [PW-1:0]             prior_reg;
    logic [PW-1:0]             rem_reg;
    logic [PW-1:0]             lo_reg;
    logic [PW-1:0]             quo_reg;
    logic                      sat_reg;
    logic [SW-1:0]             step_reg;
    logic                      m_valid_reg;
    logic [95:0]               m_data_reg;
    logic                      m_user_reg;

    logic [CW-1:0] eff_a;
    logic [CW-1:0] rd_addr;
    logic [PW-1:0] rd_data;
    logic          price_zero;
    logic          ratio_ovf;
    logic          skip_div;
    logic [PW:0]   trial;
    logic [PW:0]   trial_diff;
    logic          trial_ge;

    always_comb begin
        if (32'(lookback_reg) > 32'(MAX_LOOKBACK)) begin
            eff_a = CW'(MAX_LOOKBACK);
        end else if (lookback_reg == '0) begin
            eff_a = CW'(1);
        end else begin
            eff_a = CW'(lookback_reg);
        end
    end

    assign rd_addr    = head_reg - idx_reg;
    assign price_zero = (price_reg == '0);
    assign ratio_ovf  = ({8'd0, wmax_reg} >= {price_reg, 8'd0});
    assign skip_div   = newp_reg | price_zero | ratio_ovf;
    assign trial      = {rem_reg, lo_reg[PW-1]};
    assign trial_diff = trial - {1'b0, price_reg};
    assign trial_ge   = (trial >= {1'b0, price_reg});

    lmrt_ram #(
        .WIDTH (PW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (head_reg + CW'(1)),
        .wdata (price_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookback_reg <= lmrt_pkg::LB_RESET;
        end else if (cfg_valid && cfg_ready) begin
            lookback_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.scan;
            if (cmd.commit) begin
                head_reg <= head_reg + CW'(1);
                if (newp_reg) begin
                    fill_reg <= CW'(1);
                end else if (32'(fill_reg) < 32'(MAX_LOOKBACK)) begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            price_reg <= s_tdata;
            newp_reg  <= s_tuser;
            a_reg     <= eff_a;
            idx_reg   <= '0;
            acc_reg   <= '0;
        end else begin
            if (cmd.scan) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (pend_reg && pend_ok_reg && (rd_data > acc_reg)) begin
                acc_reg <= rd_data;
            end
        end
        pend_ok_reg <= (idx_reg < fill_reg);

        if (cmd.commit) begin
            if (newp_reg) begin
                wmax_reg  <= price_reg;
                prior_reg <= '0;
            end else begin
                wmax_reg  <= (price_reg > acc_reg) ? price_reg : acc_reg;
                prior_reg <= acc_reg;
            end
        end

        if (cmd.div_init) begin
            rem_reg  <= {8'd0, wmax_reg[PW-1:8]};
            lo_reg   <= {wmax_reg[7:0], 24'd0};
            step_reg <= '0;
            if (newp_reg) begin
                quo_reg <= lmrt_pkg::RATIO_ONE;
                sat_reg <= 1'b0;
            end else if (price_zero || ratio_ovf) begin
                quo_reg <= lmrt_pkg::RATIO_SAT;
                sat_reg <= 1'b1;
            end else begin
                quo_reg <= '0;
                sat_reg <= 1'b0;
            end
        end else if (cmd.div_step) begin
            rem_reg  <= trial_ge ? trial_diff[PW-1:0] : trial[PW-1:0];
            lo_reg   <= {lo_reg[PW-2:0], 1'b0};
            quo_reg  <= {quo_reg[PW-2:0], trial_ge};
            step_reg <= step_reg + SW'(1);
        end

        if (cmd.out_load) begin
            m_data_reg <= {prior_reg, wmax_reg, quo_reg};
            m_user_reg <= sat_reg;
        end
    end

    assign status.scan_last = (idx_reg == (a_reg - CW'(1)));
    assign status.skip_div  = skip_div;
    assign status.div_last  = (step_reg == SW'(lmrt_pkg::DIV_STEPS - 1));
    assign status.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/lookback_max_ratio_tracker.sv -----
// ----------------------------------------------------------------------------
// lookback_max_ratio_tracker
// Sliding-window maximum over daily Q16.16 prices with a Q8.24 max/price
// ratio. One sample is processed at a time. For an ordinary sample the
// previous window is scanned out of the history RAM one entry per cycle,
// then the maximum settles, the price is stored and the divider is set up,
// and the bit-serial restoring divider produces one quotient bit per cycle.
// A zero price or a ratio that would overflow skips the divider; a new path
// skips both the scan and the divider. A finished result waits in the
// output register while the next sample is already accepted. The look-back
// register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module lookback_max_ratio_tracker #(
    parameter int MAX_LOOKBACK = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: price[31:0]
    input  logic [31:0] s_tdata,
    // tuser: new_path[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    // tdata: ratio[31:0], window_max[63:32], prior_max[95:64]
    output logic [95:0] m_tdata,
    // tuser: saturated[0]
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    lmrt_pkg::ctrl_cmd_t  cmd;
    lmrt_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lmrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lmrt_datapath #(
        .MAX_LOOKBACK (MAX_LOOKBACK)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/lmrt_checker.sv -----
// ----------------------------------------------------------------------------
// lmrt_checker
// Port-level checks for the look-back maximum ratio tracker, bound to the
// top level.
// ----------------------------------------------------------------------------
module lmrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only one sample is in work at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in work");

    // A saturated result always carries the all-ones ratio.
    a_sat_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'hFFFF_FFFF)
        else $error("saturated result without saturated ratio");

    // The window maximum covers the prior maximum.
    a_max_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] >= m_tdata[95:64])
        else $error("window maximum below prior maximum");

endmodule

bind lookback_max_ratio_tracker lmrt_checker u_lmrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
